/* rtl/ctt_pkg.sv */
`timescale 1ns / 1ps

package ctt_pkg;

    // Scanner modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_NUMBER = 3'd1;
    localparam logic [2:0] MODE_SIGN   = 3'd2;
    localparam logic [2:0] MODE_UNQ    = 3'd3;
    localparam logic [2:0] MODE_QUOTED = 3'd4;

    // Token kinds
    localparam logic [2:0] KIND_NUMBER = 3'd0;
    localparam logic [2:0] KIND_SYMBOL = 3'd1;
    localparam logic [2:0] KIND_STRING = 3'd2;
    localparam logic [2:0] KIND_WS     = 3'd3;
    localparam logic [2:0] KIND_LF     = 3'd4;

    // Character codes with a role of their own
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic        ovf;
        logic        last;
    } ctt_res_t;

    // Results produced by one byte, oldest in r0
    typedef struct packed {
        logic [1:0] cnt;
        ctt_res_t   r0;
        ctt_res_t   r1;
    } ctt_push_t;

    function automatic logic is_num(input logic [7:0] c);
        return ((c >= CH_ZERO) && (c <= CH_NINE)) || (c == CH_DOT);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    // Bytes that close an unquoted string
    function automatic logic is_end(input logic [7:0] c);
        logic r;
        case (c)
            8'h20, 8'h2C, 8'h40, 8'h7E, 8'h5E, 8'h2F, 8'h24, 8'h26, 8'h22,
            8'h27, 8'h21, 8'h23, 8'h25, 8'h2B, 8'h2A, 8'h3D, 8'h5B, 8'h7B,
            8'h5D, 8'h7D, 8'h5C, 8'h7C, 8'h3C, 8'h3E, 8'h60, 8'h0A: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Single-byte symbols
    function automatic logic is_sym(input logic [7:0] c);
        logic r;
        case (c)
            8'h2C, 8'h40, 8'h7E, 8'h5E, 8'h2F, 8'h24, 8'h26, 8'h27, 8'h21,
            8'h23, 8'h25, 8'h2B, 8'h2A, 8'h3D, 8'h5B, 8'h7B, 8'h5D, 8'h7D,
            8'h5C, 8'h7C, 8'h3C, 8'h3E, 8'h60, 8'h2D, 8'h3A: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/ctt_scan.sv */
`timescale 1ns / 1ps

module ctt_scan #(
    parameter int POS_WIDTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        char_code,
    input  logic              end_of_text,
    output ctt_pkg::ctt_push_t push
);
    import ctt_pkg::*;

    localparam int XW = (POS_WIDTH > 16) ? POS_WIDTH + 1 : 17;
    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    logic [2:0]           mode_reg, mode_next;
    logic                 esc_reg, esc_next;
    logic [POS_WIDTH-1:0] ts_reg, ts_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic                 ovf_reg, ovf_next;

    logic                 taken;
    logic                 a_v, b_v, c_v;
    logic [2:0]           a_kind, b_kind, c_kind, bc_kind;
    logic [POS_WIDTH-1:0] c_start, bc_start;
    logic [POS_WIDTH:0]   a_end, c_end, bc_end;
    logic [POS_WIDTH:0]   p_ext, p_inc;
    ctt_res_t             res_a, res_bc;

    function automatic logic [15:0] sat16(input logic [POS_WIDTH:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        return (x > XW'(16'hFFFF)) ? 16'hFFFF : x[15:0];
    endfunction

    function automatic ctt_res_t mk_res(input logic [2:0] kind,
                                        input logic [POS_WIDTH-1:0] start,
                                        input logic [POS_WIDTH:0] end_excl,
                                        input logic ovf,
                                        input logic last);
        ctt_res_t r;
        logic [POS_WIDTH:0] s;
        logic [POS_WIDTH:0] len;
        s   = {1'b0, start};
        len = (end_excl > s) ? end_excl - s : '0;
        if (len > {1'b0, POS_MAX}) len = {1'b0, POS_MAX};
        if (len == '0) len = (POS_WIDTH+1)'(1);
        r.kind  = kind;
        r.start = sat16(s);
        r.len   = sat16(len);
        r.ovf   = ovf;
        r.last  = last;
        return r;
    endfunction

    assign p_ext = {1'b0, pos_reg};
    assign p_inc = p_ext + (POS_WIDTH+1)'(1);

    always_comb begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        ts_next   = ts_reg;
        taken     = 1'b0;
        a_v       = 1'b0;
        a_kind    = KIND_NUMBER;
        a_end     = p_ext;
        b_v       = 1'b0;
        b_kind    = KIND_LF;
        c_v       = 1'b0;
        c_kind    = KIND_STRING;
        c_start   = ts_reg;
        c_end     = p_inc;

        // Continue the open token
        unique case (mode_reg)
            MODE_NUMBER: begin
                if (is_num(char_code) || is_sign(char_code)) begin
                    taken = 1'b1;
                end else begin
                    a_v       = 1'b1;
                    a_kind    = KIND_NUMBER;
                    a_end     = p_ext;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_SIGN: begin
                if (is_num(char_code)) begin
                    mode_next = MODE_NUMBER;
                    taken     = 1'b1;
                end else begin
                    a_v       = 1'b1;
                    a_kind    = KIND_SYMBOL;
                    a_end     = {1'b0, ts_reg} + (POS_WIDTH+1)'(1);
                    mode_next = MODE_IDLE;
                end
            end
            MODE_UNQ: begin
                priority if (esc_reg) begin
                    esc_next = 1'b0;
                    taken    = 1'b1;
                end else if (char_code == CH_BSLASH) begin
                    esc_next = 1'b1;
                    taken    = 1'b1;
                end else if (is_end(char_code)) begin
                    a_v       = 1'b1;
                    a_kind    = KIND_STRING;
                    a_end     = p_ext;
                    mode_next = MODE_IDLE;
                end else begin
                    taken = 1'b1;
                end
            end
            MODE_QUOTED: begin
                taken = 1'b1;
                priority if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (char_code == CH_BSLASH) begin
                    esc_next = 1'b1;
                end else if (char_code == CH_QUOTE) begin
                    a_v       = 1'b1;
                    a_kind    = KIND_STRING;
                    a_end     = p_inc;
                    mode_next = MODE_IDLE;
                end else begin
                    esc_next = 1'b0;
                end
            end
            default: mode_next = MODE_IDLE;
        endcase

        // Open a new token with this byte
        if (!taken) begin
            priority if (char_code == CH_LF) begin
                b_v    = 1'b1;
                b_kind = KIND_LF;
            end else if (char_code == CH_SPACE) begin
                b_v    = 1'b1;
                b_kind = KIND_WS;
            end else if (is_num(char_code)) begin
                mode_next = MODE_NUMBER;
                ts_next   = pos_reg;
            end else if (is_sign(char_code)) begin
                mode_next = MODE_SIGN;
                ts_next   = pos_reg;
            end else if (is_sym(char_code)) begin
                b_v    = 1'b1;
                b_kind = KIND_SYMBOL;
            end else begin
                mode_next = (char_code == CH_QUOTE) ? MODE_QUOTED : MODE_UNQ;
                ts_next   = pos_reg;
                esc_next  = 1'b0;
            end
        end

        // Flush at end of text
        c_start = ts_next;
        if (end_of_text) begin
            priority case (mode_next)
                MODE_SIGN: begin
                    c_v    = 1'b1;
                    c_kind = KIND_SYMBOL;
                    c_end  = {1'b0, ts_next} + (POS_WIDTH+1)'(1);
                end
                MODE_NUMBER: begin
                    c_v    = 1'b1;
                    c_kind = KIND_NUMBER;
                end
                MODE_UNQ, MODE_QUOTED: begin
                    c_v    = 1'b1;
                    c_kind = KIND_STRING;
                end
                default: c_v = 1'b0;
            endcase
        end
    end

    // A one-byte token and an end-of-text flush never come from the same byte
    assign bc_kind  = b_v ? b_kind : c_kind;
    assign bc_start = b_v ? pos_reg : c_start;
    assign bc_end   = b_v ? p_inc : c_end;

    assign res_a  = mk_res(a_kind, ts_reg, a_end, ovf_reg, !(b_v || c_v));
    assign res_bc = mk_res(bc_kind, bc_start, bc_end, ovf_reg, 1'b1);

    always_comb begin
        if (a_v) begin
            push.cnt = (b_v || c_v) ? 2'd2 : 2'd1;
            push.r0  = res_a;
            push.r1  = res_bc;
        end else begin
            push.cnt = (b_v || c_v) ? 2'd1 : 2'd0;
            push.r0  = res_bc;
            push.r1  = res_bc;
        end
    end

    always_comb begin
        if (pos_reg == POS_MAX) begin
            pos_next = POS_MAX;
            ovf_next = 1'b1;
        end else begin
            pos_next = pos_reg + POS_WIDTH'(1);
            ovf_next = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            esc_reg  <= 1'b0;
            ts_reg   <= '0;
            pos_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else if (step) begin
            if (end_of_text) begin
                mode_reg <= MODE_IDLE;
                esc_reg  <= 1'b0;
                ts_reg   <= '0;
                pos_reg  <= '0;
                ovf_reg  <= 1'b0;
            end else begin
                mode_reg <= mode_next;
                esc_reg  <= esc_next;
                ts_reg   <= ts_next;
                pos_reg  <= pos_next;
                ovf_reg  <= ovf_next;
            end
        end
    end

endmodule

/* rtl/ctt_fifo.sv */
`timescale 1ns / 1ps

module ctt_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_en,
    input  ctt_pkg::ctt_push_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output ctt_pkg::ctt_res_t  out_res
);
    import ctt_pkg::*;

    localparam int DEPTH = 4;

    ctt_res_t   entry_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] n_in;
    logic       pop;

    assign n_in      = push_en ? push.cnt : 2'd0;
    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign out_res   = entry_reg[rd_ptr_reg];
    // Keep two slots free so any byte can land
    assign room      = (count_reg <= 3'(DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + n_in;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, n_in} - {2'b00, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_in != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (n_in == 2'd2) begin
            entry_reg[wr_ptr_reg + 2'd1] <= push.r1;
        end
    end

endmodule

/* rtl/command_text_tokenizer_top.sv */
`timescale 1ns / 1ps
// Command text tokenizer.
// Slave channel (s_): one text byte per request in s_tdata[7:0]; s_tlast marks
// the last byte of a text. Master channel (m_): one token per request, giving
// its kind and overflow flag in m_tuser and its start offset and length in
// m_tdata. m_tlast is high on the final token caused by a given input byte.
// A token is reported when the byte that ends it is accepted; s_tlast flushes
// any open token and restarts offsets at 0 for the next text.
// Tokens caused by a byte are written into the result queue when that byte is
// accepted. Throughput: one byte per cycle while s_tready is high. A byte can cause up to
// two tokens, which drain through a four-entry result queue at one per cycle while m_tready is high.
// s_tready is high while the queue has at least two free entries, so the
// input side keeps moving while a finished token waits on a stalled receiver;
// once the receiver has held off until fewer than two entries are free, s_tready
// drops until entries drain.
// Reset (aresetn low, synchronous): queue emptied, scanner idle, offsets and
// the overflow flag cleared.
// Offsets are POS_WIDTH bits wide and saturate at the top value; start and
// length outputs saturate at 65535.

module command_text_tokenizer_top #(
    parameter int POS_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] start_pos, [31:16] token_length
    output logic [7:0]  m_tuser,   // [2:0] token_kind, [3] pos_overflow, [7:4] zero
    output logic        m_tlast    // last_of_run
);
    import ctt_pkg::*;

    ctt_push_t push;
    ctt_res_t  out_res;
    logic      room;
    logic      step;

    // Advance the scanner on every accepted byte
    assign s_tready = room;
    assign step     = s_tvalid && room;

    ctt_scan #(
        .POS_WIDTH(POS_WIDTH)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .char_code   (s_tdata),
        .end_of_text (s_tlast),
        .push        (push)
    );

    // Hold results until the receiver takes them
    ctt_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (step),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.len, out_res.start};
    assign m_tuser = {4'b0000, out_res.ovf, out_res.kind};
    assign m_tlast = out_res.last;

endmodule

/* rtl/ctt_checker.sv */
`timescale 1ns / 1ps

module ctt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [7:0]  m_tuser,
    input logic        m_tlast
);
    import ctt_pkg::*;

    // A stalled request stays up
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // A stalled request keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("m_ payload changed while stalled");

    // Only defined token kinds leave the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[2:0] == KIND_NUMBER) || (m_tuser[2:0] == KIND_SYMBOL)
                     || (m_tuser[2:0] == KIND_STRING) || (m_tuser[2:0] == KIND_WS)
                     || (m_tuser[2:0] == KIND_LF))
        else $error("undefined token kind");

    // Every token holds at least one byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:16] != 16'd0)
        else $error("zero-length token");

    // Reset empties the result queue
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind command_text_tokenizer_top ctt_checker u_ctt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
